// ===== design/wsie_pkg.sv =====
// Package with sizes, opcodes and state codes of the weighted SAT evaluator.
`default_nettype none
package wsie_pkg;
   localparam int MAX_VARS = 256;
   localparam int MAX_CLAUSES = 1024;
   localparam int CLAUSE_SIZE = 3;
   localparam int MAX_OCCURRENCES = 16;
   localparam int WEIGHT_BITS = 16;
   localparam logic [2:0] OP_LOAD_WEIGHT = 3'd0;
   localparam logic [2:0] OP_LOAD_LITERAL = 3'd1;
   localparam logic [2:0] OP_LOAD_OCC = 3'd2;
   localparam logic [2:0] OP_SET_VALUE = 3'd3;
   localparam logic [2:0] OP_EVAL_ALL = 3'd4;
   localparam logic [2:0] OP_TOGGLE = 3'd5;
   localparam logic [0:0] CSR_VARIABLE_COUNT = 1'd0;
   localparam logic [0:0] CSR_CLAUSE_COUNT = 1'd1;
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_WSUM_RD = 4'd1;
   localparam logic [3:0] ST_WSUM_ACC = 4'd2;
   localparam logic [3:0] ST_CL_START = 4'd3;
   localparam logic [3:0] ST_LIT_RD = 4'd4;
   localparam logic [3:0] ST_LIT_ACC = 4'd5;
   localparam logic [3:0] ST_CL_DONE = 4'd6;
   localparam logic [3:0] ST_TG_RD = 4'd7;
   localparam logic [3:0] ST_TG_UPD = 4'd8;
   localparam logic [3:0] ST_OCC_RD = 4'd9;
   localparam logic [3:0] ST_OCC_GOT = 4'd10;
   localparam logic [3:0] ST_REPORT = 4'd11;
   localparam logic [3:0] ST_CLEAR = 4'd12;
endpackage
`default_nettype wire

// ===== design/weighted_sat_incremental_evaluator.sv =====
// Top level of the weighted SAT incremental evaluator.
// An item is taken at a clock edge where start is high and busy is low; its result sits on the
// rsp_ ports for the one cycle in which rsp_valid is high, and the receiver cannot stall it.
// After reset the block clears the assignment bits, the occurrence list lengths and the clause
// truth bits one entry per cycle, holding busy high meanwhile. Busy drops in the cycle after the
// result strobe. Loads, set value and unused opcodes go from the accepting edge straight to the
// strobe. Evaluate-all walks the variables and then the clauses, their counts limited to 256 and
// 1024: each variable costs a weight and assignment read plus an add, and each clause costs a
// start and an update step plus three dependent literal reads. Toggle flips the variable and
// then, for each entry of its occurrence list, does an occurrence read and a range check on top
// of the clause recheck.
`default_nettype none
module weighted_sat_incremental_evaluator
   import wsie_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [7:0]  req_var_index,
   input  wire logic [9:0]  req_clause_index,
   input  wire logic [3:0]  req_slot,
   input  wire logic        req_polarity,
   input  wire logic [15:0] req_weight_value,
   input  wire logic        req_value_bit,
   input  wire logic [4:0]  req_list_length,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [10:0] csr_data,
   output logic             rsp_valid,
   output logic [10:0]      rsp_satisfied_count,
   output logic [23:0]      rsp_weight_sum,
   output logic             rsp_all_satisfied
);
   localparam int VB = $clog2(MAX_VARS);
   localparam int CB = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
   localparam int SB = (CLAUSE_SIZE > 1) ? $clog2(CLAUSE_SIZE) : 1;
   localparam int LB = $clog2(MAX_CLAUSES * CLAUSE_SIZE);
   localparam int QB = $clog2(MAX_VARS * MAX_OCCURRENCES);
   localparam int NB = $clog2(MAX_OCCURRENCES + 1);
   localparam int VCB = $clog2(MAX_VARS + 1);
   localparam int CCB = $clog2(MAX_CLAUSES + 1);
   localparam int CLEAR_N = (MAX_VARS > MAX_CLAUSES) ? MAX_VARS : MAX_CLAUSES;
   localparam int RB = $clog2(CLEAR_N);

   logic                   asg_mem [MAX_VARS];
   logic [WEIGHT_BITS-1:0] wgt_mem [MAX_VARS];
   logic [8:0]             lit_mem [MAX_CLAUSES*CLAUSE_SIZE];
   logic [CB-1:0]          occ_mem [MAX_VARS*MAX_OCCURRENCES];
   logic [NB-1:0]          len_mem [MAX_VARS];
   logic                   ct_mem  [MAX_CLAUSES];

   logic [3:0]  state_ff, state_in;
   logic [8:0]  vcount_ff;
   logic [10:0] ccount_ff;
   logic [10:0] sat_ff, sat_in;
   logic [23:0] wsum_ff, wsum_in;
   logic [10:0] acc_cnt_ff, acc_cnt_in;
   logic [23:0] acc_sum_ff, acc_sum_in;
   logic [VCB-1:0] vi_ff, vi_in;
   logic [CCB-1:0] ci_ff, ci_in;
   logic [SB:0] li_ff, li_in;
   logic [NB:0] oi_ff, oi_in;
   logic [LB-1:0] lbase_ff, lbase_in;
   logic        t_ff, t_in;
   logic        eval_mode_ff, eval_mode_in;
   logic [7:0]  tv_ff, tv_in;
   logic [CB-1:0] cl_ff, cl_in;
   logic [NB-1:0] tlen_ff, tlen_in;
   logic [RB-1:0] clr_ff, clr_in;

   logic [VB-1:0] vrd_addr;
   logic [LB-1:0] lrd_addr;
   logic [QB-1:0] qrd_addr;
   logic [CB-1:0] crd_addr;
   logic          asg_q, ct_q;
   logic [WEIGHT_BITS-1:0] wgt_q;
   logic [8:0]    lit_q;
   logic [CB-1:0] occ_q;
   logic [NB-1:0] len_q;

   logic        asg_we, ct_we, ct_wd, asg_wd;
   logic [VB-1:0] asg_wa;
   logic [CB-1:0] ct_wa;
   logic        len_we;
   logic [VB-1:0] len_wa;
   logic [NB-1:0] len_wd;
   logic        asg_lit, lit_true;
   logic [VCB-1:0] nv;
   logic [CCB-1:0] nc;
   logic [4:0]  len_sat;
   logic [NB-1:0] len_val;
   logic        v_ok;

   assign v_ok = ({24'd0, req_var_index} < 32'(MAX_VARS));
   assign nv = (32'(vcount_ff) < 32'(MAX_VARS)) ? VCB'(vcount_ff) : VCB'(MAX_VARS);
   assign nc = (32'(ccount_ff) < 32'(MAX_CLAUSES)) ? CCB'(ccount_ff) : CCB'(MAX_CLAUSES);
   assign len_sat = (32'(req_list_length) > 32'(MAX_OCCURRENCES)) ?
                    5'(MAX_OCCURRENCES) : req_list_length;
   assign len_val = NB'(len_sat);

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         ccount_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_VARIABLE_COUNT: vcount_ff <= csr_data[8:0];
            CSR_CLAUSE_COUNT: ccount_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      wgt_q <= wgt_mem[vrd_addr];
      len_q <= len_mem[vrd_addr];
      lit_q <= lit_mem[lrd_addr];
      occ_q <= occ_mem[qrd_addr];
      asg_q <= asg_mem[vrd_addr];
      ct_q  <= ct_mem[crd_addr];
   end

   // Second assignment read port for literal evaluation.
   logic asg_lq;
   always_ff @(posedge clock) begin
      asg_lq <= asg_mem[lit_q[VB-1:0]];
   end
   logic lit_vok_ff;
   logic lit_sign_ff;
   always_ff @(posedge clock) begin
      lit_vok_ff <= ({24'd0, lit_q[7:0]} < 32'(MAX_VARS));
      lit_sign_ff <= lit_q[8];
   end
   assign asg_lit = lit_vok_ff ? asg_lq : 1'b0;
   assign lit_true = (lit_sign_ff == asg_lit);

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         if (req_opcode == OP_LOAD_WEIGHT && v_ok)
            wgt_mem[req_var_index[VB-1:0]] <= req_weight_value[WEIGHT_BITS-1:0];
         if (req_opcode == OP_LOAD_LITERAL && {22'd0, req_clause_index} < 32'(MAX_CLAUSES)
             && {28'd0, req_slot} < 32'(CLAUSE_SIZE))
            lit_mem[LB'(32'(req_clause_index) * CLAUSE_SIZE + 32'(req_slot))] <=
               {req_polarity, req_var_index};
         if (req_opcode == OP_LOAD_OCC && v_ok
             && {28'd0, req_slot} < 32'(MAX_OCCURRENCES))
            occ_mem[QB'(32'(req_var_index) * MAX_OCCURRENCES + 32'(req_slot))] <=
               req_clause_index;
      end
      if (len_we) len_mem[len_wa] <= len_wd;
      if (asg_we) asg_mem[asg_wa] <= asg_wd;
      if (ct_we) ct_mem[ct_wa] <= ct_wd;
   end

   always_comb begin
      state_in = state_ff;
      sat_in = sat_ff;
      wsum_in = wsum_ff;
      acc_cnt_in = acc_cnt_ff;
      acc_sum_in = acc_sum_ff;
      vi_in = vi_ff;
      ci_in = ci_ff;
      li_in = li_ff;
      oi_in = oi_ff;
      lbase_in = lbase_ff;
      t_in = t_ff;
      eval_mode_in = eval_mode_ff;
      tv_in = tv_ff;
      cl_in = cl_ff;
      tlen_in = tlen_ff;
      clr_in = clr_ff;
      vrd_addr = vi_ff[VB-1:0];
      lrd_addr = LB'(32'(lbase_ff) + 32'(li_ff));
      qrd_addr = QB'(32'(tv_ff) * MAX_OCCURRENCES + 32'(oi_ff));
      crd_addr = cl_ff;
      asg_we = 1'b0;
      asg_wa = req_var_index[VB-1:0];
      asg_wd = req_value_bit;
      len_we = 1'b0;
      len_wa = req_var_index[VB-1:0];
      len_wd = len_val;
      ct_we = 1'b0;
      ct_wa = cl_ff;
      ct_wd = t_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            asg_we = (32'(clr_ff) < 32'(MAX_VARS));
            asg_wa = clr_ff[VB-1:0];
            asg_wd = 1'b0;
            len_we = (32'(clr_ff) < 32'(MAX_VARS));
            len_wa = clr_ff[VB-1:0];
            len_wd = '0;
            ct_we = (32'(clr_ff) < 32'(MAX_CLAUSES));
            ct_wa = clr_ff[CB-1:0];
            ct_wd = 1'b0;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == CLEAR_N - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_REPORT;
               tv_in = req_var_index;
               unique case (req_opcode)
                  OP_LOAD_OCC: len_we = v_ok;
                  OP_SET_VALUE: asg_we = v_ok;
                  OP_EVAL_ALL: begin
                     vi_in = '0;
                     acc_sum_in = '0;
                     acc_cnt_in = '0;
                     eval_mode_in = 1'b1;
                     state_in = ST_WSUM_RD;
                  end
                  OP_TOGGLE: begin
                     if (v_ok) begin
                        eval_mode_in = 1'b0;
                        vrd_addr = req_var_index[VB-1:0];
                        state_in = ST_TG_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WSUM_RD: begin
            if (vi_ff >= nv) begin
               ci_in = '0;
               state_in = ST_CL_START;
            end else state_in = ST_WSUM_ACC;
         end
         ST_WSUM_ACC: begin
            if (asg_q) acc_sum_in = acc_sum_ff + 24'(wgt_q);
            vi_in = vi_ff + 1'b1;
            vrd_addr = VB'(vi_ff + 1'b1);
            state_in = ST_WSUM_RD;
         end
         ST_CL_START: begin
            if (eval_mode_ff && ci_ff >= nc) begin
               wsum_in = acc_sum_ff;
               sat_in = acc_cnt_ff;
               state_in = ST_REPORT;
            end else begin
               if (eval_mode_ff) cl_in = CB'(ci_ff);
               lbase_in = LB'(32'(eval_mode_ff ? CB'(ci_ff) : cl_ff) * CLAUSE_SIZE);
               li_in = '0;
               t_in = 1'b0;
               state_in = ST_LIT_RD;
            end
         end
         ST_LIT_RD: begin
            crd_addr = cl_ff;
            state_in = ST_LIT_ACC;
         end
         ST_LIT_ACC: begin
            state_in = ST_CL_DONE;
         end
         ST_CL_DONE: begin
            if (lit_true) t_in = 1'b1;
            if (32'(li_ff) + 1 < CLAUSE_SIZE) begin
               li_in = li_ff + 1'b1;
               state_in = ST_LIT_RD;
            end else begin
               state_in = ST_TG_UPD;
            end
         end
         ST_TG_UPD: begin
            ct_we = 1'b1;
            if (eval_mode_ff) begin
               if (t_ff) acc_cnt_in = acc_cnt_ff + 11'd1;
               ci_in = ci_ff + 1'b1;
               state_in = ST_CL_START;
            end else begin
               if (ct_q != t_ff) sat_in = t_ff ? sat_ff + 11'd1 : sat_ff - 11'd1;
               oi_in = oi_ff + 1'b1;
               state_in = ST_OCC_RD;
            end
         end
         ST_TG_RD: begin
            wsum_in = asg_q ? wsum_ff - 24'(wgt_q) : wsum_ff + 24'(wgt_q);
            asg_we = 1'b1;
            asg_wa = tv_ff[VB-1:0];
            asg_wd = !asg_q;
            tlen_in = len_q;
            oi_in = '0;
            state_in = ST_OCC_RD;
         end
         ST_OCC_RD: begin
            if (32'(oi_ff) >= 32'(tlen_ff)) state_in = ST_REPORT;
            else state_in = ST_OCC_GOT;
         end
         ST_OCC_GOT: begin
            if (32'(occ_q) < 32'(MAX_CLAUSES)) begin
               cl_in = occ_q;
               state_in = ST_CL_START;
            end else begin
               oi_in = oi_ff + 1'b1;
               state_in = ST_OCC_RD;
            end
         end
         ST_REPORT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sat_ff <= '0;
         wsum_ff <= '0;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         sat_ff <= sat_in;
         wsum_ff <= wsum_in;
         clr_ff <= clr_in;
      end
      acc_cnt_ff <= acc_cnt_in;
      acc_sum_ff <= acc_sum_in;
      vi_ff <= vi_in;
      ci_ff <= ci_in;
      li_ff <= li_in;
      oi_ff <= oi_in;
      lbase_ff <= lbase_in;
      t_ff <= t_in;
      eval_mode_ff <= eval_mode_in;
      tv_ff <= tv_in;
      cl_ff <= cl_in;
      tlen_ff <= tlen_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_REPORT);
   assign rsp_satisfied_count = sat_ff;
   assign rsp_weight_sum = wsum_ff;
   assign rsp_all_satisfied = (sat_ff == ccount_ff);
endmodule
`default_nettype wire

// ===== tb/sv/weighted_sat_incremental_evaluator_test.sv =====
// Testbench for the weighted SAT incremental evaluator with a predictor and result checks.
`timescale 1ns / 100ps
module weighted_sat_incremental_evaluator_test
   import wsie_pkg::*;
();

   localparam int NUM_VARS = 256;
   localparam int NUM_CLAUSES = 1024;
   localparam int LITS = 3;
   localparam int OCC_DEPTH = 16;
   localparam int STALL_LIMIT = 20000;
   localparam logic [2:0] OP_NOP_A = 3'd6;
   localparam logic [2:0] OP_NOP_B = 3'd7;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  var_index;
      logic [9:0]  clause_index;
      logic [3:0]  slot;
      logic        polarity;
      logic [15:0] weight_value;
      logic        value_bit;
      logic [4:0]  list_length;
   } sat_item_type;

   typedef struct packed {
      logic [10:0] count;
      logic [23:0] sum;
      logic        all_sat;
   } sat_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_opcode = '0;
   logic [7:0] req_var_index = '0;
   logic [9:0] req_clause_index = '0;
   logic [3:0] req_slot = '0;
   logic req_polarity = 1'b0;
   logic [15:0] req_weight_value = '0;
   logic req_value_bit = 1'b0;
   logic [4:0] req_list_length = '0;
   logic csr_write = 1'b0;
   logic [0:0] csr_index = '0;
   logic [10:0] csr_data = '0;
   logic rsp_valid;
   logic [10:0] rsp_satisfied_count;
   logic [23:0] rsp_weight_sum;
   logic rsp_all_satisfied;

   weighted_sat_incremental_evaluator dut (.*);

   always #5 clock = ~clock;

   // Shadow of the block's tables and totals.
   bit asg[NUM_VARS];
   bit [15:0] wgt[NUM_VARS];
   bit [7:0] lit_var[NUM_CLAUSES*LITS];
   bit lit_sgn[NUM_CLAUSES*LITS];
   bit [9:0] occ_clause[NUM_VARS*OCC_DEPTH];
   bit [4:0] occ_len[NUM_VARS];
   bit clause_sat[NUM_CLAUSES];
   bit [10:0] sat_total;
   bit [23:0] weight_total;
   bit [8:0] cfg_vars;
   bit [10:0] cfg_clauses;

   // Entries already written, so that stimulus never reads an undefined one.
   bit occ_done[NUM_VARS*OCC_DEPTH];
   int clause_lim;

   sat_item_type pending_items[$];
   sat_status_type expected_status[$];
   int idle_pct = 0;
   int errors = 0;
   int stall_cycles = 0;

   function automatic bit clause_holds(int c);
      bit t;
      t = 0;
      for (int i = 0; i < LITS; i++)
         if (lit_sgn[c*LITS+i] == asg[lit_var[c*LITS+i]]) t = 1;
      return t;
   endfunction

   function automatic void predict_status(sat_item_type it);
      int nv;
      int nc;
      int v;
      int cl;
      bit t;
      bit [4:0] len;
      sat_status_type s;
      v = it.var_index;
      case (it.opcode)
         OP_LOAD_WEIGHT: wgt[v] = it.weight_value;
         OP_LOAD_LITERAL: begin
            if (it.slot < LITS) begin
               lit_var[it.clause_index*LITS+it.slot] = it.var_index;
               lit_sgn[it.clause_index*LITS+it.slot] = it.polarity;
            end
         end
         OP_LOAD_OCC: begin
            len = it.list_length > OCC_DEPTH ? 5'(OCC_DEPTH) : it.list_length;
            occ_len[v] = len;
            occ_clause[v*OCC_DEPTH+it.slot] = it.clause_index;
         end
         OP_SET_VALUE: asg[v] = it.value_bit;
         OP_EVAL_ALL: begin
            nv = cfg_vars > NUM_VARS ? NUM_VARS : cfg_vars;
            nc = cfg_clauses > NUM_CLAUSES ? NUM_CLAUSES : cfg_clauses;
            weight_total = 0;
            sat_total = 0;
            for (int i = 0; i < nv; i++)
               if (asg[i]) weight_total += wgt[i];
            for (int i = 0; i < nc; i++) begin
               clause_sat[i] = clause_holds(i);
               if (clause_sat[i]) sat_total++;
            end
         end
         OP_TOGGLE: begin
            if (asg[v]) weight_total -= wgt[v];
            else weight_total += wgt[v];
            asg[v] = ~asg[v];
            for (int i = 0; i < occ_len[v]; i++) begin
               cl = occ_clause[v*OCC_DEPTH+i];
               t = clause_holds(cl);
               if (clause_sat[cl] != t) begin
                  clause_sat[cl] = t;
                  if (t) sat_total++;
                  else sat_total--;
               end
            end
         end
         default: ;
      endcase
      s.count = sat_total;
      s.sum = weight_total;
      s.all_sat = (sat_total == cfg_clauses);
      expected_status.push_back(s);
   endfunction

   task automatic queue_item(sat_item_type it);
      if (it.opcode == OP_LOAD_OCC) occ_done[it.var_index*OCC_DEPTH+it.slot] = 1;
      predict_status(it);
      pending_items.push_back(it);
   endtask

   function automatic sat_item_type noise_item();
      sat_item_type it;
      it = sat_item_type'(48'({$urandom, $urandom}));
      it.clause_index = 10'($urandom_range(0, clause_lim-1));
      return it;
   endfunction

   // Occurrence load whose list length never reaches an unwritten entry.
   function automatic sat_item_type occ_item(int v, int s, int c);
      sat_item_type it;
      int p;
      it = noise_item();
      it.opcode = OP_LOAD_OCC;
      it.var_index = 8'(v);
      it.slot = 4'(s);
      it.clause_index = 10'(c);
      p = 0;
      while (p < OCC_DEPTH && (occ_done[v*OCC_DEPTH+p] || p == s)) p++;
      if (p == OCC_DEPTH && $urandom_range(0, 3) == 0)
         it.list_length = 5'($urandom_range(16, 31));
      else it.list_length = 5'($urandom_range(0, p));
      return it;
   endfunction

   function automatic sat_item_type random_item();
      sat_item_type it;
      int r;
      it = noise_item();
      r = $urandom_range(0, 99);
      if (r < 10) begin
         it.opcode = OP_LOAD_WEIGHT;
         case ($urandom_range(0, 3))
            0: it.weight_value = 16'h0000;
            1: it.weight_value = 16'hFFFF;
            default: ;
         endcase
      end else if (r < 20) begin
         it.opcode = OP_LOAD_LITERAL;
         if ($urandom_range(0, 9) < 7) it.slot = 4'($urandom_range(0, LITS-1));
      end else if (r < 35) begin
         it = occ_item($urandom_range(0, 255), $urandom_range(0, 15),
                       $urandom_range(0, clause_lim-1));
      end else if (r < 48) begin
         it.opcode = OP_SET_VALUE;
      end else if (r < 56 && cfg_clauses <= clause_lim) begin
         it.opcode = OP_EVAL_ALL;
      end else if (r < 95) begin
         it.opcode = OP_TOGGLE;
         if ($urandom_range(0, 1)) it.var_index = 8'($urandom_range(0, 15));
      end else begin
         it.opcode = $urandom_range(0, 1) ? OP_NOP_A : OP_NOP_B;
      end
      return it;
   endfunction

   task automatic write_reg(logic [0:0] idx, logic [10:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      if (idx == CSR_VARIABLE_COUNT) cfg_vars = data[8:0];
      else cfg_clauses = data;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || expected_status.size() != 0 || start)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic run_random(int vars, int clauses, int count, int pct);
      wait_drained();
      write_reg(CSR_VARIABLE_COUNT, 11'(vars));
      write_reg(CSR_CLAUSE_COUNT, 11'(clauses));
      idle_pct = pct;
      for (int i = 0; i < count; i++) queue_item(random_item());
   endtask

   // Driver: holds an item until the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            automatic sat_item_type it = pending_items.pop_front();
            start <= 1'b1;
            req_opcode <= it.opcode;
            req_var_index <= it.var_index;
            req_clause_index <= it.clause_index;
            req_slot <= it.slot;
            req_polarity <= it.polarity;
            req_weight_value <= it.weight_value;
            req_value_bit <= it.value_bit;
            req_list_length <= it.list_length;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_status.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("Unexpected result: count %0d sum %0d all %0d",
                           rsp_satisfied_count, rsp_weight_sum, rsp_all_satisfied);
            end else begin
               automatic sat_status_type e = expected_status.pop_front();
               if (rsp_satisfied_count !== e.count || rsp_weight_sum !== e.sum ||
                   rsp_all_satisfied !== e.all_sat) begin
                  errors++;
                  if (errors <= 10)
                     $display("Mismatch: expected count %0d sum %0d all %0d, got %0d %0d %0d",
                              e.count, e.sum, e.all_sat, rsp_satisfied_count,
                              rsp_weight_sum, rsp_all_satisfied);
               end
            end
         end
         if (rsp_valid || (start && !busy)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      sat_item_type it;
      clause_lim = 64;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_reg(CSR_VARIABLE_COUNT, 11'd256);
      write_reg(CSR_CLAUSE_COUNT, 11'd64);
      for (int v = 0; v < NUM_VARS; v++) begin
         it = noise_item();
         it.opcode = OP_LOAD_WEIGHT;
         it.var_index = 8'(v);
         queue_item(it);
      end
      for (int k = 0; k < 64*LITS; k++) begin
         it = noise_item();
         it.opcode = OP_LOAD_LITERAL;
         it.clause_index = 10'(k / LITS);
         it.slot = 4'(k % LITS);
         queue_item(it);
      end
      // Directed corners.
      it = noise_item(); it.opcode = OP_NOP_A; queue_item(it);
      it = noise_item(); it.opcode = OP_NOP_B; queue_item(it);
      it = noise_item(); it.opcode = OP_LOAD_WEIGHT; it.var_index = 8'd255;
      it.weight_value = 16'hFFFF; queue_item(it);
      it = noise_item(); it.opcode = OP_TOGGLE; it.var_index = 8'd255; queue_item(it);
      it = noise_item(); it.opcode = OP_TOGGLE; it.var_index = 8'd255; queue_item(it);
      it = noise_item(); it.opcode = OP_SET_VALUE; it.var_index = 8'd255;
      it.value_bit = 1'b1; queue_item(it);
      it = noise_item(); it.opcode = OP_SET_VALUE; it.var_index = 8'd0;
      it.value_bit = 1'b1; queue_item(it);
      it = noise_item(); it.opcode = OP_LOAD_LITERAL; it.slot = 4'd15;
      it.var_index = 8'd255; it.clause_index = 10'd1023; it.polarity = 1'b1;
      queue_item(it);
      for (int s = 0; s < OCC_DEPTH; s++)
         queue_item(occ_item(0, s, s == 15 ? 63 : s));
      it = occ_item(0, 0, 0); it.list_length = 5'd31; queue_item(it);
      it = noise_item(); it.opcode = OP_EVAL_ALL; queue_item(it);
      it = noise_item(); it.opcode = OP_TOGGLE; it.var_index = 8'd0; queue_item(it);
      it = noise_item(); it.opcode = OP_TOGGLE; it.var_index = 8'd0; queue_item(it);
      it = noise_item(); it.opcode = OP_EVAL_ALL; queue_item(it);

      run_random(16, 8, 300, 0);
      run_random(0, 0, 200, 69);
      run_random(256, 64, 250, 0);
      run_random(100, 33, 200, 31);
      run_random(511, 64, 60, 0);
      run_random(256, 2047, 60, 31);

      wait_drained();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
